/* rtl/wsmh_pkg.sv */
// Shared types and constants for the whitespace-stripped MurmurHash2 core.
`timescale 1ns / 1ps
package wsmh_pkg;

   // MurmurHash2 32-bit multiplier
   localparam logic [31:0] MURMUR_M = 32'd1540483477;

   // Shift amounts of the word mix and the finalization
   localparam int unsigned MIX_SHIFT  = 24;
   localparam int unsigned FIN_SHIFT1 = 13;
   localparam int unsigned FIN_SHIFT2 = 15;

   // Work packet from the byte front end to the mixing back end.
   // Done in order: load the seed, mix one word, finish the hash.
   typedef struct packed {
      logic        load;      // value is the seed: h = value
      logic        mix;       // value is a full word k: mix it into h
      logic [31:0] value;
      logic        finish;    // apply tail and finalization, emit result
      logic        tail_en;   // tail holds at least one byte
      logic [23:0] tail;
      logic [31:0] count;     // kept-byte count reported with the result
   } cmd_type;

endpackage

/* rtl/wsmh_front.sv */
// Byte front end: whitespace filter, kept-byte counter, word packing, pass control.
`timescale 1ns / 1ps
module wsmh_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_mode,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last,
   input  logic               cmd_full,
   output logic               cmd_push,
   output wsmh_pkg::cmd_type  cmd_data
);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_COUNT = 3'b010,
      PH_HASH  = 3'b100
   } phase_type;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;

   phase_type   phase_ff, phase_in;
   logic [31:0] kept_ff, kept_in;
   logic [23:0] part_ff, part_in;
   logic [1:0]  slot_ff, slot_in;

   logic        accept;
   logic        is_space;
   logic        start_hash;
   logic [31:0] kept_base;
   logic [23:0] part_base;
   logic [1:0]  slot_base;
   wsmh_pkg::cmd_type cmd;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign is_space = req_data_byte inside {CH_TAB, CH_LF, CH_CR, CH_SPACE};

   // Pass control and packing
   always_comb begin
      phase_in   = phase_ff;
      kept_in    = kept_ff;
      part_in    = part_ff;
      slot_in    = slot_ff;
      cmd        = '0;
      start_hash = 1'b0;
      kept_base  = kept_ff;
      part_base  = part_ff;
      slot_base  = slot_ff;
      if (!req_mode) begin
         // counting pass; a count byte outside a count pass restarts it
         kept_base = (phase_ff == PH_COUNT) ? kept_ff : '0;
         kept_in   = kept_base + {31'd0, !is_space};
         part_in   = '0;
         slot_in   = '0;
         if (req_last) begin
            phase_in  = PH_HASH;
            cmd.load  = 1'b1;
            cmd.value = 32'd1 ^ kept_in;
         end else begin
            phase_in = PH_COUNT;
         end
      end else begin
         // hashing pass; seed on entry if not already hashing
         start_hash = (phase_ff != PH_HASH);
         if (start_hash) begin
            cmd.load  = 1'b1;
            cmd.value = 32'd1 ^ kept_ff;
            part_base = '0;
            slot_base = '0;
         end
         part_in = part_base;
         slot_in = slot_base;
         if (!is_space) begin
            case (slot_base)
               2'd0: begin
                  part_in = {part_base[23:8], req_data_byte};
                  slot_in = 2'd1;
               end
               2'd1: begin
                  part_in = {part_base[23:16], req_data_byte, part_base[7:0]};
                  slot_in = 2'd2;
               end
               2'd2: begin
                  part_in = {req_data_byte, part_base[15:0]};
                  slot_in = 2'd3;
               end
               default: begin
                  cmd.mix   = 1'b1;
                  cmd.value = {req_data_byte, part_base};
                  part_in   = '0;
                  slot_in   = '0;
               end
            endcase
         end
         if (req_last) begin
            cmd.finish  = 1'b1;
            cmd.tail    = part_in;
            cmd.tail_en = (slot_in != 2'd0);
            cmd.count   = kept_ff;
            phase_in    = PH_IDLE;
            part_in     = '0;
            slot_in     = '0;
         end else begin
            phase_in = PH_HASH;
         end
      end
   end

   assign cmd_push = accept && (cmd.load || cmd.mix || cmd.finish);
   assign cmd_data = cmd;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kept_ff  <= '0;
         part_ff  <= '0;
         slot_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         kept_ff  <= kept_in;
         part_ff  <= part_in;
         slot_ff  <= slot_in;
      end
   end

`ifndef ASSERT_OFF
   // End of a counting pass always seeds the hash
   a_count_end_seeds: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_mode && req_last) |-> (cmd_push && cmd_data.load))
      else $error("counting pass end did not issue a seed");
   // Between bytes the packing slot is empty outside a hashing pass
   a_slot_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HASH) |-> (slot_ff == 2'd0))
      else $error("partial word held outside hashing pass");
`endif

endmodule

/* rtl/wsmh_fifo.sv */
// Small flop-based queue of work packets between front end and back end.
`timescale 1ns / 1ps
module wsmh_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wsmh_pkg::cmd_type  din,
   output logic               full,
   input  logic               pop,
   output wsmh_pkg::cmd_type  dout,
   output logic               empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   wsmh_pkg::cmd_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

`ifndef ASSERT_OFF
   // Front end must hold off while the queue is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   // A stored packet is visible the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> !empty)
      else $error("pushed packet lost");
`endif

endmodule

/* rtl/wsmh_back.sv */
// Mixing back end: sequencer around one constant multiplier, plus result register.
`timescale 1ns / 1ps
module wsmh_back (
   input  logic               clock,
   input  logic               reset,
   input  wsmh_pkg::cmd_type  cmd_data,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [31:0]        rsp_hash_value,
   output logic [31:0]        rsp_kept_count
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_LOAD = 8'b0000_0010,
      S_K1   = 8'b0000_0100,
      S_K2   = 8'b0000_1000,
      S_K3   = 8'b0001_0000,
      S_TAIL = 8'b0010_0000,
      S_FIN1 = 8'b0100_0000,
      S_FIN2 = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   wsmh_pkg::cmd_type cmd_ff, cmd_in;
   logic [31:0]       h_ff, h_in;
   logic [31:0]       k_ff, k_in;
   logic              res_valid_ff, res_valid_in;
   logic [31:0]       res_hash_ff, res_hash_in;
   logic [31:0]       res_count_ff, res_count_in;

   logic [31:0]       mul_a;
   logic [31:0]       prod;
   logic              res_free;

   assign res_free = !res_valid_ff || rsp_pop;
   assign prod     = mul_a * wsmh_pkg::MURMUR_M;

   // Multiplier operand per step
   always_comb begin
      case (state_ff)
         S_K1:    mul_a = cmd_ff.value;
         S_K2:    mul_a = k_ff ^ (k_ff >> wsmh_pkg::MIX_SHIFT);
         S_K3:    mul_a = h_ff;
         S_TAIL:  mul_a = h_ff ^ {8'd0, cmd_ff.tail};
         S_FIN1:  mul_a = h_ff ^ (h_ff >> wsmh_pkg::FIN_SHIFT1);
         default: mul_a = h_ff;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      res_valid_in = res_valid_ff && !rsp_pop;
      res_hash_in  = res_hash_ff;
      res_count_in = res_count_ff;
      cmd_pop      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (cmd_ff.load) begin
               h_in = cmd_ff.value;
            end
            if (cmd_ff.mix) begin
               state_in = S_K1;
            end else if (cmd_ff.finish) begin
               state_in = S_TAIL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_K1: begin
            k_in     = prod;
            state_in = S_K2;
         end
         S_K2: begin
            k_in     = prod;
            state_in = S_K3;
         end
         S_K3: begin
            h_in     = prod ^ k_ff;
            state_in = cmd_ff.finish ? S_TAIL : S_IDLE;
         end
         S_TAIL: begin
            if (cmd_ff.tail_en) begin
               h_in = prod;
            end
            state_in = S_FIN1;
         end
         S_FIN1: begin
            h_in     = prod;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            // wait here while the previous result is still unread
            if (res_free) begin
               res_valid_in = 1'b1;
               res_hash_in  = h_ff ^ (h_ff >> wsmh_pkg::FIN_SHIFT2);
               res_count_in = cmd_ff.count;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      h_ff         <= h_in;
      k_ff         <= k_in;
      res_hash_ff  <= res_hash_in;
      res_count_ff <= res_count_in;
   end

   assign rsp_empty      = !res_valid_ff;
   assign rsp_hash_value = res_hash_ff;
   assign rsp_kept_count = res_count_ff;

`ifndef ASSERT_OFF
   // A result only appears out of the last finalization step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(res_valid_ff) |-> $past(state_ff == S_FIN2))
      else $error("result written outside finalization");
   // Packets are only taken when the sequencer is free
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == S_LOAD))
      else $error("packet taken while busy");
`endif

endmodule

/* rtl/whitespace_stripped_murmur2_hash_core.sv */
// Top level of the whitespace-stripped MurmurHash2 core.
//
// Usage: the file's bytes are sent twice on the req_ queue port, first with
// req_mode 0 (counting pass), then with req_mode 1 (hashing pass); req_last
// marks the final byte of each pass. Bytes 9, 10, 13 and 32 are skipped.
// A byte is taken when req_push is high and req_full is low. Only the last
// byte of a hashing pass yields a result: the hash and the kept-byte count
// appear on rsp_ while rsp_empty is low and are taken with rsp_pop.
// Throughput: one byte per cycle on the input while the work queue has room.
// The back end runs one constant multiplier in sequence: a seed passes the
// load step, a completed 4-byte word the load step and K1, K2 and K3, and
// the finish load, tail, FIN1 and FIN2; a kept-byte stream can outpace it.
// rsp_empty falls once the last byte's packet has passed the queue and the
// load, tail, FIN1 and FIN2 steps, plus K1 to K3 if that byte ends a word.
// If the receiver stalls, the finished result waits in its register while
// new bytes keep entering until the work queue fills; then req_full rises.
// Reset clears the pass state, the kept count, the queue and the result.
`timescale 1ns / 1ps
module whitespace_stripped_murmur2_hash_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_hash_value,
   output logic [31:0] rsp_kept_count
);

   wsmh_pkg::cmd_type push_cmd, pop_cmd;
   logic cmd_push, cmd_full, cmd_pop, cmd_empty;

   // Byte classification and packing
   wsmh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd_data      (push_cmd)
   );

   // Work queue
   wsmh_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (push_cmd),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .dout  (pop_cmd),
      .empty (cmd_empty)
   );

   // Mixing and finalization
   wsmh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_data       (pop_cmd),
      .cmd_empty      (cmd_empty),
      .cmd_pop        (cmd_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hash_value (rsp_hash_value),
      .rsp_kept_count (rsp_kept_count)
   );

endmodule

/* sim/wsmh_tb_pkg.sv */
// Scoreboard for the whitespace-stripped MurmurHash2 core testbench.
`timescale 1ns / 1ps
package wsmh_tb_pkg;

   // Pass selector values on req_mode
   localparam logic MODE_COUNT = 1'b0;
   localparam logic MODE_HASH  = 1'b1;

   // Bytes that the core skips
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;

   typedef enum logic [1:0] {
      PASS_IDLE  = 2'd0,
      PASS_COUNT = 2'd1,
      PASS_HASH  = 2'd2
   } pass_type;

   typedef struct packed {
      logic [31:0] hash_value;
      logic [31:0] kept_count;
   } digest_type;

   function automatic bit is_blank(logic [7:0] b);
      return b == CH_TAB || b == CH_LF || b == CH_CR || b == CH_SPACE;
   endfunction

   class stripped_hash_checker;
      pass_type    pass_state;
      logic [31:0] kept_total;
      logic [31:0] running_hash;
      logic [23:0] partial_word;
      logic [1:0]  byte_slot;
      digest_type  pending_digests[$];
      int unsigned error_count;
      int unsigned digests_due;

      function new();
         pass_state   = PASS_IDLE;
         kept_total   = '0;
         running_hash = '0;
         partial_word = '0;
         byte_slot    = '0;
         error_count  = 0;
         digests_due  = 0;
      endfunction

      // Seed is 1 xor the kept count
      function void begin_hashing();
         pass_state   = PASS_HASH;
         running_hash = 32'd1 ^ kept_total;
         partial_word = '0;
         byte_slot    = '0;
      endfunction

      // Advance the model by one accepted item; queue a digest on a final hash byte
      function void take_byte(logic mode, logic [7:0] b, logic last);
         logic [31:0] k;
         logic [31:0] h;
         digest_type  d;
         if (mode == MODE_COUNT) begin
            // a counting byte outside a counting pass restarts everything
            if (pass_state != PASS_COUNT) begin
               pass_state   = PASS_COUNT;
               kept_total   = '0;
               running_hash = '0;
               partial_word = '0;
               byte_slot    = '0;
            end
            if (!is_blank(b))
               kept_total = kept_total + 32'd1;
            if (last)
               begin_hashing();
            return;
         end

         if (pass_state != PASS_HASH)
            begin_hashing();

         // pack kept bytes little-endian, mix on each full word
         if (!is_blank(b)) begin
            if (byte_slot == 2'd3) begin
               k = {b, partial_word};
               k = k * wsmh_pkg::MURMUR_M;
               k = (k ^ (k >> wsmh_pkg::MIX_SHIFT)) * wsmh_pkg::MURMUR_M;
               running_hash = (running_hash * wsmh_pkg::MURMUR_M) ^ k;
               partial_word = '0;
               byte_slot    = '0;
            end else begin
               partial_word[8*byte_slot +: 8] = b;
               byte_slot = byte_slot + 2'd1;
            end
         end

         // tail and finalization
         if (last) begin
            h = running_hash;
            if (byte_slot != 2'd0)
               h = (h ^ {8'd0, partial_word}) * wsmh_pkg::MURMUR_M;
            h = (h ^ (h >> wsmh_pkg::FIN_SHIFT1)) * wsmh_pkg::MURMUR_M;
            h = h ^ (h >> wsmh_pkg::FIN_SHIFT2);
            d.hash_value = h;
            d.kept_count = kept_total;
            pending_digests.push_back(d);
            digests_due++;
            pass_state   = PASS_IDLE;
            running_hash = '0;
            partial_word = '0;
            byte_slot    = '0;
         end
      endfunction

      // Compare one accepted result with the oldest expected digest
      function void match_result(logic [31:0] hash_value, logic [31:0] kept_count);
         digest_type exp_d;
         if (pending_digests.size() == 0) begin
            $display("%0t: unexpected result: hash %h count %h", $time, hash_value,
                     kept_count);
            error_count++;
            return;
         end
         exp_d = pending_digests.pop_front();
         if (exp_d.hash_value !== hash_value) begin
            $display("%0t: hash_value mismatch: expected %h, actual %h", $time,
                     exp_d.hash_value, hash_value);
            error_count++;
         end
         if (exp_d.kept_count !== kept_count) begin
            $display("%0t: kept_count mismatch: expected %h, actual %h", $time,
                     exp_d.kept_count, kept_count);
            error_count++;
         end
      endfunction
   endclass

endpackage

/* sim/tb_whitespace_stripped_murmur2_hash_core.sv */
// Testbench top: random and directed byte streams against the hash core.
`timescale 1ns / 1ps
module tb_whitespace_stripped_murmur2_hash_core;

   localparam int unsigned CYCLE_LIMIT     = 300000;
   localparam int unsigned HOLD_OFF_CYCLES = 600;
   localparam int unsigned DRAIN_CYCLES    = 40;
   localparam int unsigned TARGET_BYTES    = 650;
   localparam int unsigned TARGET_DIGESTS  = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_mode = 1'b0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last = 1'b0;
   logic        rsp_pop = 1'b0;
   logic        req_full;
   logic        rsp_empty;
   logic [31:0] rsp_hash_value;
   logic [31:0] rsp_kept_count;

   wsmh_tb_pkg::stripped_hash_checker hash_board = new();
   int unsigned cycle_count = 0;
   int unsigned bytes_offered = 0;
   int unsigned results_taken = 0;
   bit          steady_sender = 1'b0;
   logic [7:0]  content[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   whitespace_stripped_murmur2_hash_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_data_byte  (req_data_byte),
      .req_last       (req_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hash_value (rsp_hash_value),
      .rsp_kept_count (rsp_kept_count)
   );

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one item, wait for it to be taken, then update the model
   task automatic send_byte(input logic mode, input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= b;
      req_last      <= last;
      do @(posedge clock); while (req_full);
      hash_board.take_byte(mode, b, last);
      bytes_offered++;
   endtask

   // Send the first n content bytes as one pass; last marks the final one if asked
   task automatic send_pass(input logic mode, input int unsigned n, input bit with_last);
      for (int unsigned i = 0; i < n; i++)
         send_byte(mode, content[i], with_last && (i == n - 1));
   endtask

   // Random content with plenty of whitespace
   task automatic fill_content(input int unsigned len);
      content.delete();
      repeat (len) begin
         if ($urandom_range(0, 9) < 3) begin
            case ($urandom_range(0, 3))
               0: content.push_back(wsmh_tb_pkg::CH_TAB);
               1: content.push_back(wsmh_tb_pkg::CH_LF);
               2: content.push_back(wsmh_tb_pkg::CH_CR);
               default: content.push_back(wsmh_tb_pkg::CH_SPACE);
            endcase
         end else begin
            content.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Result side: random pops, with two long hold-offs to back up the core
   initial begin : result_drain
      int unsigned gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (results_taken == 3 || results_taken == 30)
            gap = HOLD_OFF_CYCLES;
         else
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         hash_board.match_result(rsp_hash_value, rsp_kept_count);
         results_taken++;
      end
   end

   // Stimulus
   initial begin : byte_source
      int unsigned len;
      int unsigned kind;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // full file: extreme bytes, one full word plus a tail, whitespace final byte
      content = '{8'h00, 8'hFF, wsmh_tb_pkg::CH_TAB, 8'h41, wsmh_tb_pkg::CH_SPACE,
                  8'h7A, wsmh_tb_pkg::CH_CR, 8'h80, wsmh_tb_pkg::CH_LF};
      send_pass(wsmh_tb_pkg::MODE_COUNT, content.size(), 1'b1);
      send_pass(wsmh_tb_pkg::MODE_HASH, content.size(), 1'b1);
      // hashing byte while idle, seeded from the kept count left over
      send_byte(wsmh_tb_pkg::MODE_HASH, 8'h55, 1'b1);
      // counting byte in the middle of a hashing pass abandons it
      send_byte(wsmh_tb_pkg::MODE_HASH, 8'h31, 1'b0);
      send_byte(wsmh_tb_pkg::MODE_COUNT, 8'h32, 1'b1);
      send_byte(wsmh_tb_pkg::MODE_HASH, 8'h33, 1'b1);
      // hashing byte in the middle of a counting pass
      send_byte(wsmh_tb_pkg::MODE_COUNT, 8'h61, 1'b0);
      send_byte(wsmh_tb_pkg::MODE_HASH, 8'h62, 1'b1);

      // mostly well-formed files, some broken sequences and noise
      while (bytes_offered < TARGET_BYTES || hash_board.digests_due < TARGET_DIGESTS) begin
         steady_sender = ($urandom_range(0, 4) == 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         kind = $urandom_range(0, 9);
         fill_content(len);
         case (kind)
            6: send_pass(wsmh_tb_pkg::MODE_HASH, len, 1'b1);
            7: send_pass(wsmh_tb_pkg::MODE_COUNT, $urandom_range(1, len), 1'b0);
            8: begin
               send_pass(wsmh_tb_pkg::MODE_COUNT, len, 1'b1);
               send_pass(wsmh_tb_pkg::MODE_HASH, $urandom_range(1, len), 1'b0);
            end
            9: begin
               repeat (len)
                  send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 5) == 0);
            end
            5: begin
               // hashing pass over different content than was counted
               send_pass(wsmh_tb_pkg::MODE_COUNT, len, 1'b1);
               fill_content(len);
               send_pass(wsmh_tb_pkg::MODE_HASH, len, 1'b1);
            end
            default: begin
               send_pass(wsmh_tb_pkg::MODE_COUNT, len, 1'b1);
               send_pass(wsmh_tb_pkg::MODE_HASH, len, 1'b1);
            end
         endcase
      end
      req_push <= 1'b0;

      // drain outstanding results, then allow for stragglers
      while (hash_board.pending_digests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (hash_board.error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/wsmh_pkg.sv
rtl/wsmh_front.sv
rtl/wsmh_fifo.sv
rtl/wsmh_back.sv
rtl/whitespace_stripped_murmur2_hash_core.sv
sim/wsmh_tb_pkg.sv
sim/tb_whitespace_stripped_murmur2_hash_core.sv
